FILE: hw/rtl/edfm_pkg.sv
// Shared constants and types of the edge density feature map.
`timescale 1ns / 1ps
`default_nettype none

package edfm_pkg;

  // Line store depth, the widest frame the block handles.
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  // Accepted-item counter, wide enough to pass width + 1 for any width.
  localparam int FED_W     = COL_W + 1;

  localparam int PIX_W     = 8;
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 16;
  localparam int WIN       = 3;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic [PIX_W-1:0] FULL_PIX = 8'hff;

  // Window sum of at most nine full pixels, weight of at most four.
  localparam int SUM_W  = 12;
  localparam int WT_W   = 3;
  localparam int PROD_W = 14;

  // Division by 36 as multiplication by ceil(2^19 / 36); exact for products below 2^15.
  localparam int DIV_MUL_W = 14;
  localparam int DIV_SHIFT = 19;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 14'd14564;

  // Which window rows and columns of the current centre lie inside the frame, and whether it is the last pixel.
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
    logic eof;
  } pos_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/edfm_ram.sv
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module edfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/edge_density_feature_map.sv
// Top level of the edge density feature map: line stores, 3x3 window and scaling pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Pixels enter in raster order, one item per clock unless stalled, and each result is the
// in-frame 3x3 sum around a centre pixel times its direction weight, divided by 36.
// Results lag the input by image_width + 1 items, so image_width + 1 pad items (tuser
// high) after the last pixel drain the frame; the last pixel's result carries tlast.
// Without back-pressure the sustained rate is one item per clock, set by the single
// read-modify-write of each line store entry per item, with forwarding when the same
// column is touched by neighboring items. The item that completes a window reaches its
// result via memory read, window sum, weight product and reciprocal divide. After reset
// both line stores are swept to zero, taking no item; configuration writes still apply.
module edge_density_feature_map (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [edfm_pkg::PIX_W-1:0]       in_tdata,   // [7:0] pixel_value
  input  wire logic [0:0]                       in_tuser,   // [0] is_pad
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [edfm_pkg::PIX_W-1:0]       out_tdata,  // [7:0] feature_value
  output logic                                  out_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [edfm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [edfm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import edfm_pkg::*;

  // Configuration
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [31:0]         w_ext;
  logic [31:0]         w_eff;
  logic [31:0]         w_eff_m1;
  logic [31:0]         w_eff_p1;
  logic [COL_W-1:0]    wm1;
  logic [FED_W-1:0]    w_p1;
  logic [HEIGHT_W-1:0] h_eff;
  logic [HEIGHT_W-1:0] hm1;

  // Clearing sweep
  logic             clr_busy_r;
  logic [COL_W-1:0] clr_addr_r;

  // Input position counters
  logic [COL_W-1:0]    col_r,  col_nxt;
  logic [HEIGHT_W-1:0] row_r,  row_nxt;
  logic [FED_W-1:0]    fed_r,  fed_nxt;
  logic [COL_W-1:0]    ccol_r, ccol_nxt;
  logic [HEIGHT_W-1:0] crow_r, crow_nxt;
  logic                all_in_r, all_in_nxt;

  logic             step;
  logic             emit_in;
  logic [PIX_W-1:0] pix_in;
  pos_flags_t       flags_in;

  // Stage 1: line store data returns
  logic             v1_r;
  logic             emit1_r;
  logic [COL_W-1:0] idx1_r;
  logic [PIX_W-1:0] pix1_r;
  pos_flags_t       flags1_r;
  logic             fwd1_r;
  logic [PIX_W-1:0] fwd_up1_r;
  logic [PIX_W-1:0] fwd_mid1_r;
  logic [PIX_W-1:0] up_rdata;
  logic [PIX_W-1:0] mid_rdata;
  logic [PIX_W-1:0] up_old;
  logic [PIX_W-1:0] mid_old;
  logic             fwd_in;

  logic [PIX_W-1:0] win_r   [WIN][WIN];
  logic [PIX_W-1:0] win_nxt [WIN][WIN];
  logic [WIN-1:0]   row_ok;
  logic [WIN-1:0]   col_ok;
  logic [SUM_W-1:0] sum1;
  logic [WT_W-1:0]  wt1;

  // Stages 2 and 3, output register
  logic                  v2_r;
  logic [SUM_W-1:0]      sum2_r;
  logic [WT_W-1:0]       wt2_r;
  logic                  eof2_r;
  logic                  v3_r;
  logic [PROD_W-1:0]     prod3_r;
  logic                  eof3_r;
  logic                  out_valid_r;
  logic [PIX_W-1:0]      feat_r;
  logic                  last_r;
  logic [PROD_W+DIV_MUL_W-1:0] qprod;

  logic mv1, mv2, mv3;
  logic ready1, ready2, ready3, ready_o;

  logic             up_we, mid_we;
  logic [COL_W-1:0] ram_waddr;
  logic [PIX_W-1:0] up_wdata, mid_wdata;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = 32'(width_r);
    if (w_ext == 32'd0) begin
      w_eff = 32'd1;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_eff_m1 = w_eff - 32'd1;
    w_eff_p1 = w_eff + 32'd1;
    wm1      = w_eff_m1[COL_W-1:0];
    w_p1     = w_eff_p1[FED_W-1:0];
    h_eff    = (height_r == '0) ? HEIGHT_W'(1) : height_r;
    hm1      = h_eff - HEIGHT_W'(1);
  end

  // ---------------------------------------------------------------- clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- handshake chain
  always_comb begin
    ready_o = !out_valid_r || out_tready;
    mv3     = v3_r && ready_o;
    ready3  = !v3_r || ready_o;
    mv2     = v2_r && ready3;
    ready2  = !v2_r || ready3;
    mv1     = v1_r && (!emit1_r || ready2);
    ready1  = !v1_r || mv1;
  end

  assign in_tready = !clr_busy_r && ready1;

  // A pad before the frame's last pixel is taken but changes nothing.
  assign step    = in_tvalid && in_tready && (!in_tuser[0] || all_in_r);
  assign pix_in  = all_in_r ? '0 : in_tdata;
  assign emit_in = !(fed_r < w_p1);

  always_comb begin
    flags_in.top = crow_r != '0;
    flags_in.bot = crow_r < hm1;
    flags_in.lft = ccol_r != '0;
    flags_in.rgt = ccol_r < wm1;
    flags_in.eof = (crow_r >= hm1) && (ccol_r >= wm1);
  end

  // ---------------------------------------------------------------- position counters
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    fed_nxt    = fed_r;
    ccol_nxt   = ccol_r;
    crow_nxt   = crow_r;
    all_in_nxt = all_in_r;
    if (step) begin
      if (!all_in_r && (row_r >= hm1) && (col_r >= wm1)) begin
        all_in_nxt = 1'b1;
      end
      if (col_r >= wm1) begin
        col_nxt = '0;
        if (row_r != '1) begin
          row_nxt = row_r + HEIGHT_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (!emit_in) begin
        fed_nxt = fed_r + FED_W'(1);
      end else if (flags_in.eof) begin
        // Frame done: the next item starts a new frame.
        col_nxt    = '0;
        row_nxt    = '0;
        fed_nxt    = '0;
        ccol_nxt   = '0;
        crow_nxt   = '0;
        all_in_nxt = 1'b0;
      end else begin
        if (fed_r != '1) begin
          fed_nxt = fed_r + FED_W'(1);
        end
        if (ccol_r >= wm1) begin
          ccol_nxt = '0;
          crow_nxt = crow_r + HEIGHT_W'(1);
        end else begin
          ccol_nxt = ccol_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      fed_r    <= '0;
      ccol_r   <= '0;
      crow_r   <= '0;
      all_in_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      fed_r    <= fed_nxt;
      ccol_r   <= ccol_nxt;
      crow_r   <= crow_nxt;
      all_in_r <= all_in_nxt;
    end
  end

  // ---------------------------------------------------------------- line stores
  // The item leaving stage 1 writes the entry that a new item may read in the same cycle;
  // the memory returns old data then, so the written values are carried along instead.
  assign fwd_in  = mv1 && (idx1_r == col_r);
  assign up_old  = fwd1_r ? fwd_up1_r  : up_rdata;
  assign mid_old = fwd1_r ? fwd_mid1_r : mid_rdata;

  assign up_we     = clr_busy_r || mv1;
  assign mid_we    = clr_busy_r || mv1;
  assign ram_waddr = clr_busy_r ? clr_addr_r : idx1_r;
  assign up_wdata  = clr_busy_r ? '0 : mid_old;
  assign mid_wdata = clr_busy_r ? '0 : pix1_r;

  edfm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk   (clk),
    .we    (up_we),
    .waddr (ram_waddr),
    .wdata (up_wdata),
    .re    (step),
    .raddr (col_r),
    .rdata (up_rdata)
  );

  edfm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk   (clk),
    .we    (mid_we),
    .waddr (ram_waddr),
    .wdata (mid_wdata),
    .re    (step),
    .raddr (col_r),
    .rdata (mid_rdata)
  );

  // ---------------------------------------------------------------- window and weight
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = up_old;
    win_nxt[1][2] = mid_old;
    win_nxt[2][2] = pix1_r;
  end

  assign row_ok = {flags1_r.bot, 1'b1, flags1_r.top};
  assign col_ok = {flags1_r.rgt, 1'b1, flags1_r.lft};

  always_comb begin
    sum1 = '0;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum1 = sum1 + SUM_W'(win_nxt[r][c]);
        end
      end
    end
    wt1 = '0;
    if (win_nxt[1][1] == FULL_PIX) begin
      if (flags1_r.lft && flags1_r.rgt &&
          win_nxt[1][0] == FULL_PIX && win_nxt[1][2] == FULL_PIX) begin
        wt1 = wt1 + WT_W'(1);
      end
      if (flags1_r.top && flags1_r.bot &&
          win_nxt[0][1] == FULL_PIX && win_nxt[2][1] == FULL_PIX) begin
        wt1 = wt1 + WT_W'(1);
      end
      if (flags1_r.lft && flags1_r.rgt && flags1_r.top && flags1_r.bot) begin
        if (win_nxt[0][2] == FULL_PIX && win_nxt[2][0] == FULL_PIX) begin
          wt1 = wt1 + WT_W'(1);
        end
        if (win_nxt[0][0] == FULL_PIX && win_nxt[2][2] == FULL_PIX) begin
          wt1 = wt1 + WT_W'(1);
        end
      end
    end
  end

  assign qprod = (PROD_W + DIV_MUL_W)'(prod3_r) * (PROD_W + DIV_MUL_W)'(DIV_MUL);

  // ---------------------------------------------------------------- pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (step) begin
        v1_r <= 1'b1;
      end else if (mv1) begin
        v1_r <= 1'b0;
      end
      if (mv1 && emit1_r) begin
        v2_r <= 1'b1;
      end else if (mv2) begin
        v2_r <= 1'b0;
      end
      if (mv2) begin
        v3_r <= 1'b1;
      end else if (mv3) begin
        v3_r <= 1'b0;
      end
      if (mv3) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (mv1) begin
        win_r <= win_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- pipeline payload
  always_ff @(posedge clk) begin
    if (step) begin
      emit1_r    <= emit_in;
      idx1_r     <= col_r;
      pix1_r     <= pix_in;
      flags1_r   <= flags_in;
      fwd1_r     <= fwd_in;
      fwd_up1_r  <= mid_old;
      fwd_mid1_r <= pix1_r;
    end
    if (mv1 && emit1_r) begin
      sum2_r <= sum1;
      wt2_r  <= wt1;
      eof2_r <= flags1_r.eof;
    end
    if (mv2) begin
      prod3_r <= PROD_W'(sum2_r) * PROD_W'(wt2_r);
      eof3_r  <= eof2_r;
    end
    if (mv3) begin
      feat_r <= qprod[DIV_SHIFT +: PIX_W];
      last_r <= eof3_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = feat_r;
  assign out_tlast  = last_r;

  // ---------------------------------------------------------------- assertions
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready && !v1_r)
    else $error("item taken while line stores are being cleared");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("result changed while waiting to be taken");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit_in && flags_in.eof) |=>
      (col_r == '0 && row_r == '0 && fed_r == '0 && !all_in_r))
    else $error("position counters not cleared after frame end");

  a_fwd_same_column: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && fwd1_r) |-> (idx1_r == $past(idx1_r)))
    else $error("forwarded line store data from a different column");

endmodule

`default_nettype wire

FILE: dv/edfm_checker.sv
// Checker for the edge density feature map: mirrors the window pipeline and compares results.
`timescale 1ns / 1ps

module edfm_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [edfm_pkg::PIX_W-1:0]       in_tdata,   // [7:0] pixel_value
  input  wire logic [0:0]                       in_tuser,   // [0] is_pad
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [edfm_pkg::PIX_W-1:0]       out_tdata,  // [7:0] feature_value
  input  wire logic                             out_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [edfm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [edfm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int unsigned                           mismatches,
  output int unsigned                           features_pending
);
  import edfm_pkg::*;

  localparam int unsigned WINDOW_DIVISOR = 36;

  typedef struct packed {
    logic [PIX_W-1:0] feature;
    logic             last;
  } feature_t;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;

  logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [WIN][WIN];

  int unsigned in_row, in_col, fed, ctr_row, ctr_col;
  bit          frame_in;
  int unsigned error_total;

  feature_t expected_features [$];

  function automatic void restart_frame();
    in_row   = 0;
    in_col   = 0;
    fed      = 0;
    ctr_row  = 0;
    ctr_col  = 0;
    frame_in = 1'b0;
  endfunction

  // Shifts one item into the window and returns 1 when a centre pixel is complete.
  function automatic bit slide_window(input logic [PIX_W-1:0] pix, input logic pad,
                                      output feature_t res);
    int unsigned w, h, v, col, sum, wt;
    pos_flags_t  at;
    bit          row_ok, col_ok;
    res = '0;
    w = 32'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = 32'(height_reg);
    if (h == 0) h = 1;

    // A pad before the last pixel of the frame is dropped without a trace.
    if (pad && !frame_in) return 1'b0;

    v   = frame_in ? 32'd0 : 32'(pix);
    col = in_col % MAX_WIDTH;
    for (int r = 0; r < WIN; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2]        = upper_line[col];
    win[1][2]        = middle_line[col];
    win[2][2]        = v[PIX_W-1:0];
    upper_line[col]  = middle_line[col];
    middle_line[col] = v[PIX_W-1:0];

    if (!frame_in && in_row >= h - 1 && in_col >= w - 1) frame_in = 1'b1;
    if (in_col >= w - 1) begin
      in_col = 0;
      if (in_row < 32'hffff) in_row++;
    end else begin
      in_col++;
    end

    if (fed < w + 1) begin
      fed++;
      return 1'b0;
    end

    at.top = ctr_row > 0;
    at.bot = ctr_row + 1 < h;
    at.lft = ctr_col > 0;
    at.rgt = ctr_col + 1 < w;
    at.eof = ctr_row >= h - 1 && ctr_col >= w - 1;

    sum = 0;
    for (int r = 0; r < WIN; r++) begin
      row_ok = (r == 0) ? at.top : ((r == 2) ? at.bot : 1'b1);
      for (int c = 0; c < WIN; c++) begin
        col_ok = (c == 0) ? at.lft : ((c == 2) ? at.rgt : 1'b1);
        if (row_ok && col_ok) sum += 32'(win[r][c]);
      end
    end

    // Pairs through a full centre count only when every tap is inside the frame.
    wt = 0;
    if (win[1][1] == FULL_PIX) begin
      if (at.lft && at.rgt && win[1][0] == FULL_PIX && win[1][2] == FULL_PIX) wt++;
      if (at.top && at.bot && win[0][1] == FULL_PIX && win[2][1] == FULL_PIX) wt++;
      if (at.lft && at.rgt && at.top && at.bot) begin
        if (win[0][2] == FULL_PIX && win[2][0] == FULL_PIX) wt++;
        if (win[0][0] == FULL_PIX && win[2][2] == FULL_PIX) wt++;
      end
    end

    res.feature = PIX_W'((sum * wt) / WINDOW_DIVISOR);
    res.last    = at.eof;

    if (at.eof) begin
      restart_frame();
    end else begin
      if (fed < 32'hffffffff) fed++;
      if (ctr_col >= w - 1) begin
        ctr_col = 0;
        ctr_row++;
      end else begin
        ctr_col++;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    feature_t want, fresh;
    if (!rst_n) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int r = 0; r < WIN; r++)
        for (int c = 0; c < WIN; c++) win[r][c] = '0;
      restart_frame();
      expected_features.delete();
      error_total = 0;
    end else begin
      // Compare before predicting so that a premature result cannot match.
      if (out_tvalid && out_tready) begin
        if (expected_features.size() == 0) begin
          $error("unexpected item: feature_value %0d end_of_frame %0b", out_tdata, out_tlast);
          error_total++;
        end else begin
          want = expected_features.pop_front();
          if (want.feature !== out_tdata) begin
            $error("feature_value: expected %0d, actual %0d", want.feature, out_tdata);
            error_total++;
          end
          if (want.last !== out_tlast) begin
            $error("end_of_frame: expected %0b, actual %0b", want.last, out_tlast);
            error_total++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (slide_window(in_tdata, in_tuser[0], fresh)) expected_features.push_back(fresh);
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_IMAGE_WIDTH:  width_reg  = cfg_wdata[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_wdata[HEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
    features_pending <= expected_features.size();
    mismatches       <= error_total;
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top of the edge density feature map: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import edfm_pkg::*;

  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned SETTLE_CYCLES = 16;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned features_pending;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  always #1 clk = ~clk;

  edge_density_feature_map DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  edfm_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tlast        (out_tlast),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .features_pending (features_pending)
  );

  // Result side back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && !quiet && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned frame_width(input logic [15:0] w_word);
    int unsigned w;
    w = 32'(w_word[WIDTH_W-1:0]);
    if (w == 0) return 1;
    return (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  // Called at a clock edge; returns at the edge where the item is accepted.
  task automatic send_item(input logic [PIX_W-1:0] pix, input logic pad);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= pix;
    in_tuser[0] <= pad;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (features_pending != 0);
  endtask

  // Registers change only between frames, once the pipeline has emptied.
  task automatic configure(input logic [15:0] w_word, input logic [15:0] h_word);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_IMAGE_WIDTH;
    cfg_wdata <= w_word;
    @(posedge clk);
    cfg_addr  <= REG_IMAGE_HEIGHT;
    cfg_wdata <= h_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_frame(input logic [15:0] w_word, input logic [15:0] h_word,
                           output int unsigned sent);
    int unsigned w, h, full_pct;
    w        = frame_width(w_word);
    h        = (h_word == 0) ? 32'd1 : 32'(h_word);
    full_pct = $urandom_range(10, 90);
    sent     = 0;
    configure(w_word, h_word);
    for (int unsigned i = 0; i < w * h; i++) begin
      // A stray pad inside the frame must leave no trace.
      if (!quiet && $urandom_range(0, 19) == 0) send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 63) == 0) pause_until_drained();
      if ($urandom_range(1, 100) <= full_pct) send_item(FULL_PIX, 1'b0);
      else send_item(PIX_W'($urandom_range(0, 255)), 1'b0);
      sent++;
    end
    // Drain the last row; pixels here are discarded like pads.
    for (int unsigned i = 0; i <= w; i++) begin
      send_item(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
      sent++;
    end
    if ($urandom_range(0, 3) == 0) send_item(PIX_W'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int unsigned random_items, sent;
    logic [15:0] w_word, h_word;
    random_items = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Zero width and height fall back to a single-pixel frame.
    configure(16'd0, 16'd0);
    send_item(FULL_PIX, 1'b0);
    send_item(8'h5a, 1'b0);
    send_item(8'h00, 1'b1);

    // All-full 3x3 frame: the centre reaches the largest feature value.
    configure(16'd3, 16'd3);
    repeat (4) send_item(FULL_PIX, 1'b0);
    send_item(8'h33, 1'b1);
    repeat (5) send_item(FULL_PIX, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(FULL_PIX, 1'b0);
    send_item(8'h00, 1'b1);

    configure(16'd2, 16'd2);
    send_item(8'haa, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(FULL_PIX, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b1);

    while (random_items < 900) begin
      w_word = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(11, 40))
                                            : 16'($urandom_range(1, 10));
      h_word = 16'($urandom_range(1, 8));
      if ($urandom_range(0, 11) == 0) w_word = 16'd0;
      if ($urandom_range(0, 11) == 0) h_word = 16'd0;
      if ($urandom_range(0, 3) == 0) w_word[15:12] = 4'($urandom_range(1, 15));
      quiet = ($urandom_range(0, 5) == 0);
      run_frame(w_word, h_word, sent);
      quiet = 1'b0;
      random_items += sent;
    end

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
